@@ design/cdi_pkg.sv @@
// Shared types and constants for the compounding delay index pipeline.
// Used by cdi_trig and compounding_delay_index; depends on nothing.
`default_nettype none

package cdi_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_FOCUS_RADIUS  = 3'd0;
  localparam logic [2:0] REG_ELEMENT_PITCH = 3'd1;
  localparam logic [2:0] REG_NUM_ELEMENTS  = 3'd2;
  localparam logic [2:0] REG_SAMPLES_PER_UM = 3'd3;
  localparam logic [2:0] REG_LAST_INDEX    = 3'd4;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 24;
  localparam int unsigned IN_DATA_W   = 80;
  localparam int unsigned OUT_DATA_W  = 16;

  // One radian step of the angle code in Q30.
  localparam logic [30:0] RAD_PER_UNIT = 31'd102944;
  localparam logic [30:0] Q30_ONE      = 31'd1 << 30;

  // Taylor divisors: sine steps 0..3, cosine steps 4..7. Each division is a
  // multiplication by a rounded-up reciprocal, exact for dividends below 2^30.
  localparam int unsigned HORNER_SH [8] = '{37, 36, 35, 33, 36, 35, 34, 31};
  localparam logic [30:0] HORNER_RCP [8] = '{
    31'(((64'd1 << 37) + 64'd71) / 64'd72),
    31'(((64'd1 << 36) + 64'd41) / 64'd42),
    31'(((64'd1 << 35) + 64'd19) / 64'd20),
    31'(((64'd1 << 33) + 64'd5) / 64'd6),
    31'(((64'd1 << 36) + 64'd55) / 64'd56),
    31'(((64'd1 << 35) + 64'd29) / 64'd30),
    31'(((64'd1 << 34) + 64'd11) / 64'd12),
    31'(((64'd1 << 31) + 64'd1) / 64'd2)
  };

  // Signed sine and cosine in sign and Q30 magnitude form.
  typedef struct packed {
    logic        sin_neg;
    logic [30:0] sin_mag;
    logic        cos_neg;
    logic [30:0] cos_mag;
  } trig_t;

endpackage

`default_nettype wire

@@ design/cdi_trig.sv @@
// Twelve-stage pipelined sine and cosine of a 16-bit angle code.
// Depends on cdi_pkg for the Taylor constants and trig_t.
`default_nettype none

module cdi_trig (
  input  wire logic          clk,
  input  wire logic          advance,
  input  wire logic [15:0]   angle,
  output cdi_pkg::trig_t     trig
);

  logic [29:0] x_d  [0:9];
  logic [29:0] x2_d [1:7];
  logic [1:0]  q_d  [0:10];
  logic        sw_d [0:10];
  logic [29:0] ps [4];
  logic [29:0] pc [4];
  logic [30:0] ts [4];
  logic [30:0] tc [4];
  logic [30:0] s_fin;
  logic [30:0] c_fin;

  logic [13:0] r_raw;
  logic        swap;
  logic [13:0] r_oct;
  logic [30:0] x_full;
  logic [59:0] x_sq;
  logic [60:0] s_prod;

  // Fold the angle into the first octant.
  assign r_raw  = angle[13:0];
  assign swap   = r_raw > 14'd8192;
  assign r_oct  = swap ? 14'(15'd16384 - {1'b0, r_raw}) : r_raw;
  assign x_full = 31'(r_oct) * cdi_pkg::RAD_PER_UNIT;
  assign x_sq   = 60'(x_d[0]) * 60'(x_d[0]);
  assign s_prod = 61'(x_d[9]) * 61'(ts[3]);

  always_ff @(posedge clk) begin
    if (advance) begin
      x_d[0]  <= x_full[29:0];
      q_d[0]  <= angle[15:14];
      sw_d[0] <= swap;
      x2_d[1] <= x_sq[59:30];
      for (int j = 1; j <= 9; j++) begin
        x_d[j] <= x_d[j-1];
      end
      for (int j = 2; j <= 7; j++) begin
        x2_d[j] <= x2_d[j-1];
      end
      for (int j = 1; j <= 10; j++) begin
        q_d[j]  <= q_d[j-1];
        sw_d[j] <= sw_d[j-1];
      end
      s_fin <= s_prod[60:30];
      c_fin <= tc[3];
    end
  end

  // Each Horner step takes two stages: the x^2 product, then the division.
  for (genvar k = 0; k < 4; k++) begin : g_horner
    logic [30:0] tin_s;
    logic [30:0] tin_c;
    logic [60:0] mp_s;
    logic [60:0] mp_c;
    logic [60:0] mr_s;
    logic [60:0] mr_c;

    if (k == 0) begin : g_first
      assign tin_s = cdi_pkg::Q30_ONE;
      assign tin_c = cdi_pkg::Q30_ONE;
    end else begin : g_next
      assign tin_s = ts[k-1];
      assign tin_c = tc[k-1];
    end

    assign mp_s = 61'(x2_d[1+2*k]) * 61'(tin_s);
    assign mp_c = 61'(x2_d[1+2*k]) * 61'(tin_c);
    assign mr_s = 61'(ps[k]) * 61'(cdi_pkg::HORNER_RCP[k]);
    assign mr_c = 61'(pc[k]) * 61'(cdi_pkg::HORNER_RCP[k+4]);

    always_ff @(posedge clk) begin
      if (advance) begin
        ps[k] <= mp_s[59:30];
        pc[k] <= mp_c[59:30];
        ts[k] <= cdi_pkg::Q30_ONE - 31'(mr_s >> cdi_pkg::HORNER_SH[k]);
        tc[k] <= cdi_pkg::Q30_ONE - 31'(mr_c >> cdi_pkg::HORNER_SH[k+4]);
      end
    end
  end

  // Undo the octant fold, then apply the quadrant.
  logic [30:0] s0;
  logic [30:0] c0;
  cdi_pkg::trig_t trig_next;

  assign s0 = sw_d[10] ? c_fin : s_fin;
  assign c0 = sw_d[10] ? s_fin : c_fin;

  always_comb begin
    case (q_d[10])
      2'd0: trig_next = '{sin_neg: 1'b0, sin_mag: s0, cos_neg: 1'b0, cos_mag: c0};
      2'd1: trig_next = '{sin_neg: 1'b0, sin_mag: c0, cos_neg: 1'b1, cos_mag: s0};
      2'd2: trig_next = '{sin_neg: 1'b1, sin_mag: s0, cos_neg: 1'b1, cos_mag: c0};
      default: trig_next = '{sin_neg: 1'b1, sin_mag: c0, cos_neg: 1'b0, cos_mag: s0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      trig <= trig_next;
    end
  end

endmodule

`default_nettype wire

@@ design/cdi_isqrt.sv @@
// Thirty-stage pipelined integer square root, one result bit per stage.
// Stand-alone; used twice by compounding_delay_index.
`default_nettype none

module cdi_isqrt (
  input  wire logic        clk,
  input  wire logic        advance,
  input  wire logic [59:0] radicand,
  output logic      [29:0] root
);

  logic [59:0] rem_r [30];
  logic [60:0] res_r [30];

  for (genvar j = 0; j < 30; j++) begin : g_stage
    localparam logic [60:0] BIT = 61'd1 << (2 * (29 - j));
    logic [59:0] rem_in;
    logic [60:0] res_in;
    logic [60:0] trial;

    if (j == 0) begin : g_first
      assign rem_in = radicand;
      assign res_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign res_in = res_r[j-1];
    end

    assign trial = res_in + BIT;

    always_ff @(posedge clk) begin
      if (advance) begin
        if ({1'b0, rem_in} >= trial) begin
          rem_r[j] <= rem_in - trial[59:0];
          res_r[j] <= (res_in >> 1) + BIT;
        end else begin
          rem_r[j] <= rem_in;
          res_r[j] <= res_in >> 1;
        end
      end
    end
  end

  assign root = res_r[29][29:0];

endmodule

`default_nettype wire

@@ design/compounding_delay_index.sv @@
// One item per cycle sustained while s_tready stays high.
// The pipeline has 49 stages: trig (12), geometry (4), square root (30), scaling (3).
// A two-entry output buffer keeps s_tready registered; it drops only when both entries are full.
// Reset clears all valid bits and loads the register defaults; there is no clearing pass.
// Top level: delay index for diverging-wave compounding. Uses cdi_pkg, cdi_trig, cdi_isqrt.
`default_nettype none

module compounding_delay_index #(
  parameter int MAX_ELEMENTS = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // s_tdata fields, lowest bit up: point_radius_um[17:0], point_angle[33:18],
  // focus_angle[49:34], offset_um[68:50], element_index[76:69], zero fill.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [cdi_pkg::IN_DATA_W-1:0] s_tdata,
  // m_tdata fields, lowest bit up: sample_index[15:0].
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [cdi_pkg::OUT_DATA_W-1:0] m_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [cdi_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [cdi_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int PIPE_DEPTH = 49;
  localparam int TRIG_DEPTH = 12;
  localparam int OFF_DEPTH  = 46;

  // Configuration registers. The user must write only while the pipeline is empty; not enforced.
  logic [17:0] focus_radius_um;
  logic [11:0] element_pitch_um;
  logic [8:0]  num_elements;
  logic [23:0] samples_per_um;
  logic [15:0] last_index;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      focus_radius_um  <= 18'd20000;
      element_pitch_um <= 12'd300;
      num_elements     <= 9'd128;
      samples_per_um   <= 24'd871566;
      last_index       <= 16'd4095;
    end else if (cfg_valid) begin
      case (cfg_index)
        cdi_pkg::REG_FOCUS_RADIUS:   focus_radius_um  <= cfg_data[17:0];
        cdi_pkg::REG_ELEMENT_PITCH:  element_pitch_um <= cfg_data[11:0];
        cdi_pkg::REG_NUM_ELEMENTS: begin
          if (32'(cfg_data[8:0]) > 32'(MAX_ELEMENTS)) begin
            num_elements <= 9'(MAX_ELEMENTS);
          end else begin
            num_elements <= cfg_data[8:0];
          end
        end
        cdi_pkg::REG_SAMPLES_PER_UM: samples_per_um <= cfg_data[23:0];
        cdi_pkg::REG_LAST_INDEX:     last_index     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline moves together; it only halts while the output buffer's
  // second entry is occupied.
  logic skid_valid;
  logic advance;

  assign advance  = !skid_valid;
  assign s_tready = advance;

  logic [17:0] in_radius;
  logic [15:0] in_pangle;
  logic [15:0] in_fangle;
  logic [18:0] in_offset;
  logic [7:0]  in_element;

  assign in_radius  = s_tdata[17:0];
  assign in_pangle  = s_tdata[33:18];
  assign in_fangle  = s_tdata[49:34];
  assign in_offset  = s_tdata[68:50];
  assign in_element = s_tdata[76:69];

  // Valid bits and side data travel beside the arithmetic.
  logic        vld       [PIPE_DEPTH];
  logic [17:0] radius_d  [TRIG_DEPTH];
  logic [7:0]  element_d [TRIG_DEPTH];
  logic [18:0] offset_d  [OFF_DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < PIPE_DEPTH; j++) begin
        vld[j] <= 1'b0;
      end
    end else if (advance) begin
      vld[0] <= s_tvalid;
      for (int j = 1; j < PIPE_DEPTH; j++) begin
        vld[j] <= vld[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      radius_d[0]  <= in_radius;
      element_d[0] <= in_element;
      offset_d[0]  <= in_offset;
      for (int j = 1; j < TRIG_DEPTH; j++) begin
        radius_d[j]  <= radius_d[j-1];
        element_d[j] <= element_d[j-1];
      end
      for (int j = 1; j < OFF_DEPTH; j++) begin
        offset_d[j] <= offset_d[j-1];
      end
    end
  end

  // Stages 0 to 11: sine and cosine of both angles.
  cdi_pkg::trig_t point_trig;
  cdi_pkg::trig_t focus_trig;

  cdi_trig u_point_trig (
    .clk     (clk),
    .advance (advance),
    .angle   (in_pangle),
    .trig    (point_trig)
  );

  cdi_trig u_focus_trig (
    .clk     (clk),
    .advance (advance),
    .angle   (in_fangle),
    .trig    (focus_trig)
  );

  // Stage 12: Cartesian coordinates in Q8 micrometres. Each length times
  // trig magnitude is truncated before the sign goes back on.
  function automatic logic signed [27:0] scale_len(input logic [17:0] len,
                                                   input logic neg,
                                                   input logic [30:0] mag);
    logic [48:0] prod;
    logic signed [27:0] v;
    prod = 49'(len) * 49'(mag);
    v    = $signed({1'b0, prod[48:22]});
    return neg ? -v : v;
  endfunction

  logic signed [10:0] elem_factor;
  logic signed [23:0] elem_mul;

  // Element position factor 2*index - N + 1, half pitches from the centre.
  assign elem_factor = $signed({2'b0, element_d[TRIG_DEPTH-1], 1'b1}) -
                       $signed({2'b0, num_elements});
  assign elem_mul    = elem_factor * $signed({1'b0, element_pitch_um});

  logic signed [27:0] xp;
  logic signed [27:0] zp;
  logic signed [27:0] xf;
  logic signed [27:0] zf;
  logic signed [30:0] xe;

  always_ff @(posedge clk) begin
    if (advance) begin
      xp <= scale_len(radius_d[TRIG_DEPTH-1], point_trig.sin_neg, point_trig.sin_mag);
      zp <= scale_len(radius_d[TRIG_DEPTH-1], point_trig.cos_neg, point_trig.cos_mag);
      xf <= scale_len(focus_radius_um, focus_trig.sin_neg, focus_trig.sin_mag);
      zf <= scale_len(focus_radius_um, focus_trig.cos_neg, focus_trig.cos_mag);
      xe <= {elem_mul, 7'b0};
    end
  end

  // Stage 13: magnitudes of the coordinate differences.
  function automatic logic [28:0] mag29(input logic signed [30:0] d);
    logic signed [30:0] a;
    a = d[30] ? -d : d;
    return a[28:0];
  endfunction

  logic [28:0] dxf_mag;
  logic [28:0] dzf_mag;
  logic [28:0] dxr_mag;
  logic [28:0] dzr_mag;

  always_ff @(posedge clk) begin
    if (advance) begin
      dxf_mag <= mag29(31'(xp) - 31'(xf));
      dzf_mag <= mag29(31'(zp) - 31'(zf));
      dxr_mag <= mag29(31'(xp) - xe);
      dzr_mag <= mag29(31'(zp));
    end
  end

  // Stage 14: squares in Q16. Stage 15: sums of squares.
  logic [57:0] dxf_sq;
  logic [57:0] dzf_sq;
  logic [57:0] dxr_sq;
  logic [57:0] dzr_sq;
  logic [59:0] focus_sum;
  logic [59:0] elem_sum;

  always_ff @(posedge clk) begin
    if (advance) begin
      dxf_sq    <= 58'(dxf_mag) * 58'(dxf_mag);
      dzf_sq    <= 58'(dzf_mag) * 58'(dzf_mag);
      dxr_sq    <= 58'(dxr_mag) * 58'(dxr_mag);
      dzr_sq    <= 58'(dzr_mag) * 58'(dzr_mag);
      focus_sum <= 60'(dxf_sq) + 60'(dzf_sq);
      elem_sum  <= 60'(dxr_sq) + 60'(dzr_sq);
    end
  end

  // Stages 16 to 45: both distances, floored, in Q8 micrometres.
  logic [29:0] dist_focus;
  logic [29:0] dist_elem;

  cdi_isqrt u_focus_sqrt (
    .clk      (clk),
    .advance  (advance),
    .radicand (focus_sum),
    .root     (dist_focus)
  );

  cdi_isqrt u_elem_sqrt (
    .clk      (clk),
    .advance  (advance),
    .radicand (elem_sum),
    .root     (dist_elem)
  );

  // Stage 46: total path. Stage 47: scale to samples. Stage 48: clamp.
  logic signed [32:0] path;
  logic               path_nonpos;
  logic [23:0]        idx_raw;
  logic [15:0]        sample_index;
  logic [55:0]        idx_prod;

  assign idx_prod = 56'(path[31:0]) * 56'(samples_per_um);

  always_ff @(posedge clk) begin
    if (advance) begin
      path <= $signed({3'b0, dist_focus}) + $signed({3'b0, dist_elem}) -
              $signed({6'b0, offset_d[OFF_DEPTH-1], 8'b0});
      path_nonpos <= path[32] || (path == '0);
      idx_raw     <= idx_prod[55:32];
      if (path_nonpos) begin
        sample_index <= '0;
      end else if (idx_raw > 24'(last_index)) begin
        sample_index <= last_index;
      end else begin
        sample_index <= idx_raw[15:0];
      end
    end
  end

  // Output register plus one skid entry. An item leaving the pipeline while
  // the output register is held parks in the skid entry.
  logic        pipe_out;
  logic [15:0] skid_data;

  assign pipe_out = vld[PIPE_DEPTH-1] && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_tready || !m_tvalid) begin
      m_tvalid   <= skid_valid || pipe_out;
      skid_valid <= 1'b0;
    end else if (pipe_out) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tready || !m_tvalid) begin
      m_tdata <= skid_valid ? skid_data : sample_index;
    end else if (pipe_out) begin
      skid_data <= sample_index;
    end
  end

  // The skid entry is only ever occupied behind a held output item.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid entry holds an item while the output is empty");

  // The skid entry fills only from a cycle in which the output was held.
  a_skid_fill_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(m_tvalid && !m_tready))
    else $error("skid entry filled without a held output");

  // An item leaving the pipeline into a held output is parked, not dropped.
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    pipe_out && m_tvalid && !m_tready |=> skid_valid)
    else $error("pipeline item lost at the output");

endmodule

`default_nettype wire

@@ bench/tb_compounding_delay_index.sv @@
// Testbench for compounding_delay_index: stream items in, compare each sample index
// with a local fixed-point predictor. Depends on cdi_pkg and the design files only.
`timescale 1ns / 1ps

module tb_compounding_delay_index;

  // One input item. The first member lands in the highest bits, so the radius ends
  // up in the lowest bits of s_tdata, matching the port comment of the block.
  typedef struct packed {
    logic [7:0]         element;
    logic [18:0]        offset;
    logic [15:0]        focus_ang;
    logic signed [15:0] point_ang;
    logic [17:0]        radius;
  } point_req_t;

  localparam int DRAIN_CYCLES = 60;  // a little over the depth of the pipeline

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [cdi_pkg::IN_DATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [cdi_pkg::OUT_DATA_W-1:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [cdi_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [cdi_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Local copy of the configuration registers.
  int unsigned focus_radius, pitch, n_elem, samp_scale, clamp_max;

  logic [15:0] index_queue[$];  // expected sample indexes, oldest first
  int unsigned errors = 0;
  bit burst_mode = 1'b0;        // when set, the sender never idles and the receiver only for a hold-off
  int unsigned hold_off = 0;    // requested long receiver stall, in cycles

  compounding_delay_index DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  // Sine and cosine in Q30 for an angle inside the first octant. The Taylor series
  // is evaluated in nested form; each product and each division truncates.
  function automatic void octant_sincos(input longint unsigned r,
                                        output longint unsigned s,
                                        output longint unsigned c);
    longint unsigned one, x, x2, t;
    one = 64'd1 << 30;
    x = r * 64'd102944;
    x2 = (x * x) >> 30;
    t = one;
    t = one - ((x2 * t) >> 30) / 72;
    t = one - ((x2 * t) >> 30) / 42;
    t = one - ((x2 * t) >> 30) / 20;
    t = one - ((x2 * t) >> 30) / 6;
    s = (x * t) >> 30;
    t = one;
    t = one - ((x2 * t) >> 30) / 56;
    t = one - ((x2 * t) >> 30) / 30;
    t = one - ((x2 * t) >> 30) / 12;
    t = one - ((x2 * t) >> 30) / 2;
    c = t;
  endfunction

  // Signed Q30 sine and cosine of a full-turn angle code (65536 codes per turn).
  function automatic void angle_sincos(input logic [15:0] a,
                                       output longint sn, output longint cs);
    longint unsigned s0, c0;
    logic [13:0] r;
    r = a[13:0];
    if (r <= 14'd8192) begin
      octant_sincos(r, s0, c0);
    end else begin
      // Upper half of the quadrant: mirror around pi/4 and swap.
      octant_sincos(16384 - r, c0, s0);
    end
    case (a[15:14])
      2'd0: begin sn = s0;  cs = c0;  end
      2'd1: begin sn = c0;  cs = -s0; end
      2'd2: begin sn = -s0; cs = -c0; end
      default: begin sn = -c0; cs = s0; end
    endcase
  endfunction

  // Length in um times a Q30 trig value: Q8 um, magnitude truncated, sign kept.
  function automatic longint len_times(input longint unsigned len, input longint trig);
    longint unsigned mag;
    longint v;
    mag = (trig < 0) ? -trig : trig;
    v = (len * mag) >> 22;
    return (trig < 0) ? -v : v;
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint unsigned dist_q8(input longint dx, input longint dz);
    longint unsigned ax, az;
    ax = (dx < 0) ? -dx : dx;
    az = (dz < 0) ? -dz : dz;
    return floor_sqrt(ax * ax + az * az);
  endfunction

  // Sample index for one point, wave and element under the current registers.
  function automatic logic [15:0] delay_index(input point_req_t it);
    longint sp, cp, sf, cf, xp, zp, xf, zf, xe, path;
    longint unsigned idx;
    angle_sincos(it.point_ang, sp, cp);
    angle_sincos(it.focus_ang, sf, cf);
    xp = len_times(it.radius, sp);
    zp = len_times(it.radius, cp);
    xf = len_times(focus_radius, sf);
    zf = len_times(focus_radius, cf);
    // Element centre in Q8 um: (2*e - N + 1) * pitch / 2.
    xe = (2 * longint'(it.element) - longint'(n_elem) + 1) * longint'(pitch) * 128;
    path = longint'(dist_q8(xp - xf, zp - zf)) + longint'(dist_q8(xp - xe, zp))
         - longint'(it.offset) * 256;
    if (path <= 0) return 16'd0;
    idx = (longint'(path) * longint'(samp_scale)) >> 32;
    if (idx > clamp_max) idx = clamp_max;
    return idx[15:0];
  endfunction

  // ---------------------------------------------------------------- stream drivers

  // Mostly no gap, sometimes a short one, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned p;
    if (burst_mode) return 0;
    p = $urandom_range(99);
    if (p < 75) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offers one item and waits for it to be taken. Valid stays high after the
  // accepting edge so that a back-to-back item never lowers and raises it in one step.
  task automatic send_point(input point_req_t it);
    int unsigned g;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {3'b000, it};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    index_queue.push_back(delay_index(it));
  endtask

  task automatic stop_sending();
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until every expected index has arrived, then lets the pipeline settle.
  task automatic drain();
    stop_sending();
    while (index_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write; the local copy follows the same masking and clamping rules.
  // Valid drops for one cycle after each write, so writes never run back to back.
  task automatic write_reg(input logic [cdi_pkg::CFG_INDEX_W-1:0] idx,
                           input int unsigned val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[cdi_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      cdi_pkg::REG_FOCUS_RADIUS:   focus_radius = val & 32'h3FFFF;
      cdi_pkg::REG_ELEMENT_PITCH:  pitch = val & 32'hFFF;
      cdi_pkg::REG_NUM_ELEMENTS:   n_elem = ((val & 32'h1FF) > 256) ? 256 : (val & 32'h1FF);
      cdi_pkg::REG_SAMPLES_PER_UM: samp_scale = val & 32'hFFFFFF;
      cdi_pkg::REG_LAST_INDEX:     clamp_max = val & 32'hFFFF;
      default: ;  // unknown index: nothing changes
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(input int unsigned fr, pt, ne, sc, lim);
    write_reg(cdi_pkg::REG_FOCUS_RADIUS, fr);
    write_reg(cdi_pkg::REG_ELEMENT_PITCH, pt);
    write_reg(cdi_pkg::REG_NUM_ELEMENTS, ne);
    write_reg(cdi_pkg::REG_SAMPLES_PER_UM, sc);
    write_reg(cdi_pkg::REG_LAST_INDEX, lim);
  endtask

  // Random point. Most items keep radius and offset in a range where the path is
  // positive and below the clamp; the rest spread over every bit of each field.
  function automatic point_req_t random_point();
    point_req_t it;
    it.radius = ($urandom_range(99) < 70) ? 18'($urandom_range(0, 100000))
                                          : 18'($urandom);
    it.point_ang = ($urandom_range(99) < 80) ? 16'($signed($urandom_range(0, 32768)) - 16384)
                                             : 16'($urandom);
    it.focus_ang = 16'($urandom);
    it.offset = ($urandom_range(99) < 70) ? 19'($urandom_range(0, 60000)) : 19'($urandom);
    it.element = 8'($urandom);
    return it;
  endfunction

  function automatic point_req_t mk(input int unsigned r, input int pa, input int unsigned fa,
                                    input int unsigned off, input int unsigned el);
    point_req_t it;
    it.radius = r[17:0];
    it.point_ang = pa[15:0];
    it.focus_ang = fa[15:0];
    it.offset = off[18:0];
    it.element = el[7:0];
    return it;
  endfunction

  // ---------------------------------------------------------------- receiver and checker

  // Ready toggles at random, or holds low for a requested stretch counted here.
  initial begin
    int unsigned stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        m_tready <= 1'b0;
        hold_off = hold_off - 1;
      end else if (burst_mode) begin
        m_tready <= 1'b1;
      end else if (stall > 0) begin
        m_tready <= 1'b0;
        stall = stall - 1;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(99) < 12)
          stall = ($urandom_range(99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 50);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (index_queue.size() == 0) begin
        errors++;
        $display("%0t: sample_index expected none, got %0d", $time, m_tdata);
      end else begin
        logic [15:0] want;
        want = index_queue.pop_front();
        if (m_tdata !== want) begin
          errors++;
          $display("%0t: sample_index expected %0d, got %0d", $time, want, m_tdata);
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // Field extremes and the listed corner cases under the reset registers.
  task automatic test_field_extremes();
    send_point(mk(0, 0, 0, 0, 0));
    send_point(mk(262143, 0, 0, 0, 255));
    send_point(mk(50000, -16384, 0, 0, 64));
    send_point(mk(50000, 16384, 32768, 0, 127));
    send_point(mk(50000, 8192, 16384, 1000, 10));
    send_point(mk(50000, -8193, 49152, 1000, 200));
    send_point(mk(30000, -32768, 65535, 0, 3));      // angle outside range wraps
    send_point(mk(30000, 32767, 8191, 0, 250));
    send_point(mk(10000, 100, 24576, 524287, 77));   // path negative
    send_point(mk(262143, 16384, 0, 0, 128));        // index clamps
    send_point(mk(262143, -16384, 40000, 524287, 1));
    drain();
  endtask

  // Register extremes, each with a few items.
  task automatic test_register_extremes();
    set_config(0, 0, 0, 0, 0);                       // zero pitch, zero elements, zero scale
    send_point(mk(40000, 500, 0, 0, 5));
    send_point(mk(262143, -3000, 20000, 0, 255));
    drain();
    set_config(262143, 4095, 511, 16777215, 65535);  // element count above the maximum
    send_point(mk(262143, 16384, 32768, 0, 255));
    send_point(mk(1000, -16384, 12345, 0, 0));
    send_point(mk(70000, 0, 3000, 20000, 200));
    drain();
    set_config(100000, 1, 1, 16777215, 65535);       // single element, elements past the end
    send_point(mk(20000, 1234, 60000, 0, 0));
    send_point(mk(20000, -1234, 60000, 0, 255));
    drain();
    set_config(5000, 200, 256, 2000000, 4095);
    write_reg(3'd5, 1);                              // unknown indexes change nothing
    write_reg(3'd7, 12345);
    send_point(mk(60000, 4000, 100, 2000, 90));
    send_point(mk(60000, -4000, 65000, 2000, 30));
    drain();
  endtask

  // Receiver holds off long while items keep coming, so the input backs up.
  task automatic test_backpressure();
    burst_mode = 1'b1;
    @(posedge clk);
    hold_off = 300;
    repeat (120) send_point(random_point());
    burst_mode = 1'b0;
    drain();
  endtask

  // Random items over several register settings; one stretch runs without idling.
  task automatic test_random_phases();
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 0) set_config(20000, 300, 128, 871566, 4095);
      else if (ph == 5) set_config(262143, 4095, 256, 16777215, 65535);
      else set_config($urandom_range(0, 262143), $urandom_range(0, 4095),
                      $urandom_range(0, 511), $urandom_range(0, 3000000),
                      $urandom_range(0, 65535));
      burst_mode = (ph == 2);
      repeat (300) send_point(random_point());
      burst_mode = 1'b0;
      drain();
    end
  endtask

  initial begin
    focus_radius = 20000;
    pitch = 300;
    n_elem = 128;
    samp_scale = 871566;
    clamp_max = 4095;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_field_extremes();
    test_register_extremes();
    test_backpressure();
    test_random_phases();
    drain();
    if (errors == 0) begin
      $display("tb_compounding_delay_index: done, clean");
    end else begin
      $display("tb_compounding_delay_index: done, errors");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_compounding_delay_index: done, errors");
    $finish;
  end

endmodule

@@ files.f @@
design/cdi_pkg.sv
design/cdi_trig.sv
design/cdi_isqrt.sv
design/compounding_delay_index.sv
bench/tb_compounding_delay_index.sv
